>>> design/ped_pkg.sv
package ped_pkg;

  // Default sizes of the coefficient bank and of the derivative store.
  localparam int unsigned MAX_DEGREE_DEF = 6;
  localparam int unsigned MAX_DERIVS_DEF = 6;

  // Fixed field widths.
  localparam int unsigned X_W    = 32;  // sample and coefficients, Q16.16
  localparam int unsigned COEF_W = 32;
  localparam int unsigned ACC_W  = 48;  // accumulators and results, Q32.16
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned CNT_W  = 3;   // degree, derivative count and order
  localparam int unsigned AHI_W  = ACC_W - FRAC_W;
  localparam int unsigned SUM_W  = 66;  // full precision sum before saturation

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  typedef struct packed {
    logic signed [X_W-1:0] sample_x;
    logic [CNT_W-1:0]      deriv_count;
  } ped_in_t;

  typedef struct packed {
    logic [CNT_W-1:0]        order;
    logic signed [ACC_W-1:0] value;
    logic                    overflow;
    logic                    last;
  } ped_out_t;

  // Phase strobes for the shared multiply-add unit.
  typedef struct packed {
    logic ld_lo;     // operand is d[j]: low partial product, keep upper half
    logic ld_hi;     // operand is d[j-1]: high partial product and addend
    logic use_coef;  // order zero adds the coefficient instead of j*d[j-1]
  } ped_mac_ctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_RD_D,
    ST_RD_P,
    ST_MUL,
    ST_ACC,
    ST_OUT_RD,
    ST_OUT_LD
  } ped_state_e;

endpackage

>>> design/poly_eval_with_derivatives.sv
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_ready_o   in_req_i  (sample_x, deriv_count)
// result    out        out_valid_o / out_ready_i out_rsp_o (order, value, overflow, last)
// config    in         cfg_we_i, no wait         cfg_idx_i, cfg_data_i
//
// For one request with clamped degree n and derivative count k, the sequencer seeds
// the value and runs a Horner step for each coefficient index below n and each order
// from k down to 0. The results then follow in rising order; the output register
// has to empty before the next order is fetched. The pace is set by the single shared
// multiply-add unit: each Horner step reads d[j] and d[j-1] from one read port and runs
// two partial products and a sum.
// Reset clears the coefficients, the degree and all control state; no clearing pass.
// A stalled result holds the output register; the final result of a request may
// wait there while the next request is already being computed.
module poly_eval_with_derivatives import ped_pkg::*; #(
  parameter int unsigned MAX_DEGREE = MAX_DEGREE_DEF,
  parameter int unsigned MAX_DERIVS = MAX_DERIVS_DEF,
  localparam int unsigned CIDX_W = $clog2(MAX_DEGREE + 2)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  ped_in_t             in_req_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output ped_out_t            out_rsp_o,
  input  logic                cfg_we_i,
  input  logic [CIDX_W-1:0]   cfg_idx_i,
  input  logic [COEF_W-1:0]   cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned JW = (MAX_DERIVS > 0) ? $clog2(MAX_DERIVS + 1) : 1;
  // The degree register sits right after the coefficient bank.
  localparam int unsigned DEGREE_IDX = MAX_DEGREE + 1;

  // Configuration registers.
  logic signed [COEF_W-1:0] coeff_q [MAX_DEGREE+1];
  logic [CNT_W-1:0]         degree_q;

  // Request context.
  logic signed [X_W-1:0]    x_q;
  logic [JW-1:0]            k_q, k_d;
  logic [IW-1:0]            n_q, n_d;
  logic [IW-1:0]            i_q, i_d;
  logic [JW-1:0]            j_q, j_d;
  ped_state_e               state_q, state_d;

  // Derivative store: one entry per order, valid bits make unwritten entries zero.
  logic [ACC_W-1:0]         dmem [MAX_DERIVS+1];
  logic [MAX_DERIVS:0]      dvld_q, dvld_d;
  logic [MAX_DERIVS:0]      ovf_q, ovf_d;
  logic [ACC_W-1:0]         rdata_q;
  logic                     rvld_q;
  logic signed [ACC_W-1:0]  rd_val;
  logic [JW-1:0]            raddr;
  logic [JW-1:0]            waddr;
  logic [ACC_W-1:0]         wdata;
  logic                     dwe;

  // Shared multiply-add unit.
  ped_mac_ctl_t             mac_ctl;
  logic [IW-1:0]            cidx;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [ACC_W-1:0]  mac_res;
  logic                     mac_sat;

  // Output register.
  ped_out_t                 out_q;
  logic                     out_valid_q;
  logic                     out_ld;

  logic                     in_acc;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;

  // The request count is clamped to the store size and the programmed degree to the coefficient bank.
  always_comb begin
    if (int'(in_req_i.deriv_count) > MAX_DERIVS) begin
      k_d = JW'(MAX_DERIVS);
    end else begin
      k_d = JW'(in_req_i.deriv_count);
    end
    if (int'(degree_q) > MAX_DEGREE) begin
      n_d = IW'(MAX_DEGREE);
    end else begin
      n_d = IW'(degree_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c <= MAX_DEGREE; c++) begin
        coeff_q[c] <= '0;
      end
      degree_q <= '0;
    end else if (cfg_we_i) begin
      // Writes to indexes past the degree register are dropped.
      if (int'(cfg_idx_i) < DEGREE_IDX) begin
        coeff_q[cfg_idx_i[IW-1:0]] <= cfg_data_i;
      end else if (int'(cfg_idx_i) == DEGREE_IDX) begin
        degree_q <= cfg_data_i[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      dvld_q      <= '0;
      ovf_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      dvld_q  <= dvld_d;
      ovf_q   <= ovf_d;
      if (in_acc) begin
        k_q <= k_d;
        n_q <= n_d;
      end
      if (out_ld) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      x_q <= in_req_i.sample_x;
    end
    if (out_ld) begin
      out_q.order    <= CNT_W'(j_q);
      out_q.value    <= rd_val;
      out_q.overflow <= ovf_q[j_q];
      out_q.last     <= (j_q == k_q);
    end
  end

  // Store with a single registered read port.
  always_ff @(posedge clk_i) begin
    if (dwe) begin
      dmem[waddr] <= wdata;
    end
    rdata_q <= dmem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= dvld_q[raddr];
    end
  end

  assign rd_val   = rvld_q ? rdata_q : '0;
  assign coef_sel = coeff_q[cidx];

  // Sequencer. For each coefficient index i from n-1 down to 0, orders k down to 0
  // are updated in turn; each update reads d[j], then d[j-1], then writes d[j].
  always_comb begin
    state_d  = state_q;
    i_d      = i_q;
    j_d      = j_q;
    dvld_d   = dvld_q;
    ovf_d    = ovf_q;
    raddr    = j_q;
    waddr    = j_q;
    wdata    = mac_res;
    dwe      = 1'b0;
    cidx     = i_q;
    mac_ctl  = '0;
    out_ld   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          dvld_d  = '0;
          ovf_d   = '0;
          state_d = ST_INIT;
        end
      end
      ST_INIT: begin
        // The top coefficient seeds the value accumulator.
        cidx      = n_q;
        dwe       = 1'b1;
        waddr     = '0;
        wdata     = {{(ACC_W-COEF_W){coef_sel[COEF_W-1]}}, coef_sel};
        dvld_d[0] = 1'b1;
        if (n_q == '0) begin
          j_d     = '0;
          state_d = ST_OUT_RD;
        end else begin
          i_d     = n_q - 1'b1;
          j_d     = k_q;
          state_d = ST_RD_D;
        end
      end
      ST_RD_D: begin
        state_d = ST_RD_P;
      end
      ST_RD_P: begin
        if (j_q != '0) begin
          raddr = j_q - 1'b1;
        end
        mac_ctl.ld_lo = 1'b1;
        state_d       = ST_MUL;
      end
      ST_MUL: begin
        mac_ctl.ld_hi    = 1'b1;
        mac_ctl.use_coef = (j_q == '0);
        state_d          = ST_ACC;
      end
      ST_ACC: begin
        dwe           = 1'b1;
        dvld_d[j_q]   = 1'b1;
        ovf_d[j_q]    = ovf_q[j_q] | mac_sat;
        if (j_q != '0) begin
          j_d     = j_q - 1'b1;
          state_d = ST_RD_D;
        end else if (i_q == '0) begin
          state_d = ST_OUT_RD;
        end else begin
          i_d     = i_q - 1'b1;
          j_d     = k_q;
          state_d = ST_RD_D;
        end
      end
      ST_OUT_RD: begin
        // Wait for the output register to drain before fetching the next order.
        if (!out_valid_q) begin
          state_d = ST_OUT_LD;
        end
      end
      ST_OUT_LD: begin
        out_ld = 1'b1;
        if (j_q == k_q) begin
          state_d = ST_IDLE;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = ST_OUT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  ped_mac #(
    .JW (JW)
  ) u_mac (
    .clk_i  (clk_i),
    .ctl_i  (mac_ctl),
    .opnd_i (rd_val),
    .x_i    (x_q),
    .coef_i (coef_sel),
    .j_i    (j_q),
    .res_o  (mac_res),
    .sat_o  (mac_sat)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // A result is only loaded into an empty output register.
  a_out_ld_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT_LD |-> !out_valid_q)
    else $error("result loaded over a pending result");

  // The order counter never passes the requested count while working.
  a_j_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RD_D || state_q == ST_RD_P || state_q == ST_MUL ||
     state_q == ST_ACC || state_q == ST_OUT_RD || state_q == ST_OUT_LD) |-> j_q <= k_q)
    else $error("order counter beyond requested count");

  // A saturating step writes one of the two limits.
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ACC && mac_sat) |-> (mac_res == ACC_MAX || mac_res == ACC_MIN))
    else $error("saturated step did not write a limit");

  // A new request starts with clean overflow flags and only the seed pending.
  a_req_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_INIT && ovf_q == '0 && dvld_q == '0))
    else $error("request started with stale state");

endmodule

>>> design/ped_mac.sv
module ped_mac import ped_pkg::*; #(
  parameter int unsigned JW = 3
) (
  input  logic                     clk_i,
  input  ped_mac_ctl_t             ctl_i,
  input  logic signed [ACC_W-1:0]  opnd_i,
  input  logic signed [X_W-1:0]    x_i,
  input  logic signed [COEF_W-1:0] coef_i,
  input  logic [JW-1:0]            j_i,
  output logic signed [ACC_W-1:0]  res_o,
  output logic                     sat_o
);

  localparam int unsigned ADD_W = ACC_W + JW + 1;

  logic signed [FRAC_W:0]         a_lo;
  logic signed [X_W+FRAC_W:0]     lo_prod;
  logic signed [2*X_W-1:0]        hi_prod;
  logic signed [ADD_W-1:0]        j_prod;
  logic signed [ADD_W-1:0]        add_d;
  logic signed [SUM_W-1:0]        sum;
  logic [SUM_W-ACC_W:0]           top_bits;

  logic signed [X_W:0]            lo_q;
  logic signed [AHI_W-1:0]        ahi_q;
  logic signed [2*X_W-1:0]        hi_q;
  logic signed [ADD_W-1:0]        add_q;

  // x*d is split as (d_hi*2^16 + d_lo)*x; flooring by 2^16 then leaves
  // d_hi*x + floor(d_lo*x / 2^16), so no wide product is ever formed.
  assign a_lo    = $signed({1'b0, opnd_i[FRAC_W-1:0]});
  assign lo_prod = a_lo * x_i;
  assign hi_prod = ahi_q * x_i;
  assign j_prod  = $signed({1'b0, j_i}) * opnd_i;
  assign add_d   = ctl_i.use_coef ? {{(ADD_W-COEF_W){coef_i[COEF_W-1]}}, coef_i} : j_prod;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld_lo) begin
      lo_q  <= lo_prod[X_W+FRAC_W:FRAC_W];
      ahi_q <= opnd_i[ACC_W-1:FRAC_W];
    end
    if (ctl_i.ld_hi) begin
      hi_q  <= hi_prod;
      add_q <= add_d;
    end
  end

  assign sum      = SUM_W'(hi_q) + SUM_W'(lo_q) + SUM_W'(add_q);
  assign top_bits = sum[SUM_W-1:ACC_W-1];

  always_comb begin
    sat_o = !((&top_bits) || !(|top_bits));
    if (!sat_o) begin
      res_o = sum[ACC_W-1:0];
    end else if (sum[SUM_W-1]) begin
      res_o = ACC_MIN;
    end else begin
      res_o = ACC_MAX;
    end
  end

endmodule
